// ----- hw/rtl/tlpmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-level priority message queue: shared definitions
//
// Ring sizes, pointer and count widths, operation and status codes, the
// stored message word, and the pointer arithmetic of both rings.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpmq_pkg;

   // Ring sizes and the widths that follow from them.
   localparam int NRM_DEPTH = 16;
   localparam int PRI_DEPTH = 8;

   localparam int NRM_PTR_W = $clog2(2 * NRM_DEPTH);
   localparam int NRM_IDX_W = $clog2(NRM_DEPTH);
   localparam int NRM_CNT_W = $clog2(NRM_DEPTH + 1);
   localparam int PRI_PTR_W = $clog2(2 * PRI_DEPTH);
   localparam int PRI_IDX_W = $clog2(PRI_DEPTH);
   localparam int PRI_CNT_W = $clog2(PRI_DEPTH + 1);

   // Scan cursor and remaining-entry counter serve whichever ring is scanned.
   localparam int CUR_W  = (NRM_PTR_W > PRI_PTR_W) ? NRM_PTR_W : PRI_PTR_W;
   localparam int LEFT_W = (NRM_CNT_W > PRI_CNT_W) ? NRM_CNT_W : PRI_CNT_W;

   // Fixed field widths.
   localparam int OP_W     = 3;
   localparam int SINK_W   = 8;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ABORTED   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_PRIO = 1'b1;

   localparam logic [WORD_W-1:0] HIGH_PRIO_RESET = 32'd1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_FLUSH_ALL  = 3'd2,
      OP_FLUSH_SINK = 3'd3,
      OP_STATUS     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_ABORTED = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_SCAN,
      ST_FLUSH_READ,
      ST_FLUSH_CHECK,
      ST_DONE
   } state_type;

   // One stored message.
   typedef struct packed {
      logic [SINK_W-1:0] sink;
      logic [WORD_W-1:0] code;
      logic [WORD_W-1:0] param;
   } entry_type;

   // Pointers count modulo twice the depth; the entry index is the pointer
   // modulo the depth.
   function automatic logic [NRM_PTR_W-1:0] nrm_next(input logic [NRM_PTR_W-1:0] p);
      if (p == NRM_PTR_W'(2 * NRM_DEPTH - 1)) begin
         return '0;
      end
      return p + NRM_PTR_W'(1);
   endfunction

   function automatic logic [NRM_IDX_W-1:0] nrm_idx(input logic [NRM_PTR_W-1:0] p);
      logic [NRM_PTR_W-1:0] t;
      t = (p >= NRM_PTR_W'(NRM_DEPTH)) ? p - NRM_PTR_W'(NRM_DEPTH) : p;
      return t[NRM_IDX_W-1:0];
   endfunction

   function automatic logic [NRM_CNT_W-1:0] nrm_count(input logic [NRM_PTR_W-1:0] wr,
                                                      input logic [NRM_PTR_W-1:0] rd);
      logic [NRM_PTR_W:0] t;
      if (wr >= rd) begin
         t = {1'b0, wr} - {1'b0, rd};
      end else begin
         t = {1'b0, wr} + (NRM_PTR_W + 1)'(2 * NRM_DEPTH) - {1'b0, rd};
      end
      return t[NRM_CNT_W-1:0];
   endfunction

   function automatic logic [PRI_PTR_W-1:0] pri_next(input logic [PRI_PTR_W-1:0] p);
      if (p == PRI_PTR_W'(2 * PRI_DEPTH - 1)) begin
         return '0;
      end
      return p + PRI_PTR_W'(1);
   endfunction

   function automatic logic [PRI_IDX_W-1:0] pri_idx(input logic [PRI_PTR_W-1:0] p);
      logic [PRI_PTR_W-1:0] t;
      t = (p >= PRI_PTR_W'(PRI_DEPTH)) ? p - PRI_PTR_W'(PRI_DEPTH) : p;
      return t[PRI_IDX_W-1:0];
   endfunction

   function automatic logic [PRI_CNT_W-1:0] pri_count(input logic [PRI_PTR_W-1:0] wr,
                                                      input logic [PRI_PTR_W-1:0] rd);
      logic [PRI_PTR_W:0] t;
      if (wr >= rd) begin
         t = {1'b0, wr} - {1'b0, rd};
      end else begin
         t = {1'b0, wr} + (PRI_PTR_W + 1)'(2 * PRI_DEPTH) - {1'b0, rd};
      end
      return t[PRI_CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/two_level_priority_message_queue_core.sv -----
// ----------------------------------------------------------------------------
// Two-level priority message queue core
//
// Keeps a priority ring and a normal ring of messages. Pushes are routed by
// the parameter word, pops serve the priority ring first and drop flushed
// entries, and flush-by-sink walks the live window of each ring in turn.
// ----------------------------------------------------------------------------
//
//   Port group | Direction | Handshake           | Word carried
//   -----------+-----------+---------------------+------------------------------
//   req_       | in        | req_valid/req_ready | op, sink id, code, parameter
//   rsp_       | out       | rsp_valid/rsp_ready | status, message, ring counts
//   csr_       | in        | csr_valid/csr_ready | register index, write data
//
// Push, flush-all, status and refused words pass from the idle state to the
// done state and then load the result register. A pop walks the priority ring
// and then the normal ring, dropping or delivering one head entry at a time.
// Flush-by-sink reads and then checks each entry of each ring's window in turn;
// each message memory's one read port and the single sink comparator set this.
// Reset is synchronous and needs no clearing pass; the live marks clear at once.
// A new request word is taken while an earlier result still waits in the
// output register; a stalled result only holds the core in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_priority_message_queue_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [tlpmq_pkg::OP_W-1:0]           req_op,
   input  wire  [tlpmq_pkg::SINK_W-1:0]         req_sink_id,
   input  wire  [tlpmq_pkg::WORD_W-1:0]         req_msg_code,
   input  wire  [tlpmq_pkg::WORD_W-1:0]         req_msg_param,
   // Response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [tlpmq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                 rsp_out_valid,
   output logic [tlpmq_pkg::SINK_W-1:0]         rsp_out_sink_id,
   output logic [tlpmq_pkg::WORD_W-1:0]         rsp_out_code,
   output logic [tlpmq_pkg::WORD_W-1:0]         rsp_out_param,
   output logic                                 rsp_out_from_priority,
   output logic [tlpmq_pkg::NRM_CNT_W-1:0]      rsp_normal_count,
   output logic [tlpmq_pkg::PRI_CNT_W-1:0]      rsp_priority_count,
   // Configuration channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [tlpmq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tlpmq_pkg::WORD_W-1:0]         csr_wdata
);

   // Sequencer and pointer state.
   tlpmq_pkg::state_type                 state_ff, state_in;
   logic [tlpmq_pkg::NRM_PTR_W-1:0]      nrm_rd_ff, nrm_rd_in, nrm_wr_ff, nrm_wr_in;
   logic [tlpmq_pkg::PRI_PTR_W-1:0]      pri_rd_ff, pri_rd_in, pri_wr_ff, pri_wr_in;
   logic [tlpmq_pkg::NRM_DEPTH-1:0]      nrm_live_ff, nrm_live_in;
   logic [tlpmq_pkg::PRI_DEPTH-1:0]      pri_live_ff, pri_live_in;
   logic                                 ring_sel_ff, ring_sel_in;  // 1: priority ring
   logic [tlpmq_pkg::CUR_W-1:0]          cur_ff, cur_in;
   logic [tlpmq_pkg::LEFT_W-1:0]         left_ff, left_in;
   logic [tlpmq_pkg::SINK_W-1:0]         sink_ff, sink_in;
   tlpmq_pkg::status_type                status_ff, status_in;
   logic                                 hit_ff, hit_in;
   logic                                 hit_prio_ff, hit_prio_in;

   // Configuration registers.
   logic                                 aborted_ff, aborted_in;
   logic [tlpmq_pkg::WORD_W-1:0]         hpv_ff, hpv_in;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_load;
   tlpmq_pkg::status_type                rsp_status_ff;
   logic                                 rsp_hit_ff, rsp_prio_ff;
   tlpmq_pkg::entry_type                 rsp_entry_ff, rsp_entry_in;
   logic [tlpmq_pkg::NRM_CNT_W-1:0]      rsp_ncnt_ff;
   logic [tlpmq_pkg::PRI_CNT_W-1:0]      rsp_pcnt_ff;

   // Message memories.
   tlpmq_pkg::entry_type                 nrm_mem [tlpmq_pkg::NRM_DEPTH];
   tlpmq_pkg::entry_type                 pri_mem [tlpmq_pkg::PRI_DEPTH];
   tlpmq_pkg::entry_type                 nrm_rdata_ff, pri_rdata_ff, wentry;
   logic                                 nrm_we, pri_we, mem_re;

   // Derived pointer values.
   logic [tlpmq_pkg::NRM_CNT_W-1:0]      nrm_cnt;
   logic [tlpmq_pkg::PRI_CNT_W-1:0]      pri_cnt;
   logic [tlpmq_pkg::NRM_IDX_W-1:0]      nrm_scan_idx, nrm_wr_idx;
   logic [tlpmq_pkg::PRI_IDX_W-1:0]      pri_scan_idx, pri_wr_idx;
   logic [tlpmq_pkg::NRM_PTR_W-1:0]      cur_nrm;
   logic [tlpmq_pkg::PRI_PTR_W-1:0]      cur_pri;
   logic                                 sink_hit;

   assign cur_nrm    = cur_ff[tlpmq_pkg::NRM_PTR_W-1:0];
   assign cur_pri    = cur_ff[tlpmq_pkg::PRI_PTR_W-1:0];
   assign nrm_cnt    = tlpmq_pkg::nrm_count(nrm_wr_ff, nrm_rd_ff);
   assign pri_cnt    = tlpmq_pkg::pri_count(pri_wr_ff, pri_rd_ff);
   assign nrm_wr_idx = tlpmq_pkg::nrm_idx(nrm_wr_ff);
   assign pri_wr_idx = tlpmq_pkg::pri_idx(pri_wr_ff);

   // A pop scans from the read pointer, a flush from its own cursor.
   assign nrm_scan_idx = (state_ff == tlpmq_pkg::ST_POP_SCAN) ?
                         tlpmq_pkg::nrm_idx(nrm_rd_ff) : tlpmq_pkg::nrm_idx(cur_nrm);
   assign pri_scan_idx = (state_ff == tlpmq_pkg::ST_POP_SCAN) ?
                         tlpmq_pkg::pri_idx(pri_rd_ff) : tlpmq_pkg::pri_idx(cur_pri);
   assign mem_re = (state_ff == tlpmq_pkg::ST_POP_SCAN) ||
                   (state_ff == tlpmq_pkg::ST_FLUSH_READ);

   // The one sink comparator, shared between the rings.
   assign sink_hit = ((ring_sel_ff ? pri_rdata_ff.sink : nrm_rdata_ff.sink) == sink_ff);

   assign wentry.sink  = req_sink_id;
   assign wentry.code  = req_msg_code;
   assign wentry.param = req_msg_param;

   assign req_ready = (state_ff == tlpmq_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_comb begin
      aborted_in = aborted_ff;
      hpv_in     = hpv_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tlpmq_pkg::CSR_ABORTED:   aborted_in = csr_wdata[0];
            tlpmq_pkg::CSR_HIGH_PRIO: hpv_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      nrm_rd_in    = nrm_rd_ff;
      nrm_wr_in    = nrm_wr_ff;
      pri_rd_in    = pri_rd_ff;
      pri_wr_in    = pri_wr_ff;
      nrm_live_in  = nrm_live_ff;
      pri_live_in  = pri_live_ff;
      ring_sel_in  = ring_sel_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      sink_in      = sink_ff;
      status_in    = status_ff;
      hit_in       = hit_ff;
      hit_prio_in  = hit_prio_ff;
      nrm_we       = 1'b0;
      pri_we       = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         tlpmq_pkg::ST_IDLE: begin
            if (req_valid) begin
               sink_in     = req_sink_id;
               status_in   = tlpmq_pkg::STAT_OK;
               hit_in      = 1'b0;
               hit_prio_in = 1'b0;
               state_in    = tlpmq_pkg::ST_DONE;
               if (aborted_ff) begin
                  status_in = tlpmq_pkg::STAT_ABORTED;
               end else begin
                  unique case (req_op)
                     tlpmq_pkg::OP_PUSH: begin
                        if (req_msg_param == hpv_ff) begin
                           if (pri_cnt >= tlpmq_pkg::PRI_CNT_W'(tlpmq_pkg::PRI_DEPTH)) begin
                              status_in = tlpmq_pkg::STAT_FULL;
                           end else begin
                              pri_we                  = 1'b1;
                              pri_live_in[pri_wr_idx] = 1'b1;
                              pri_wr_in               = tlpmq_pkg::pri_next(pri_wr_ff);
                           end
                        end else begin
                           if (nrm_cnt >= tlpmq_pkg::NRM_CNT_W'(tlpmq_pkg::NRM_DEPTH)) begin
                              status_in = tlpmq_pkg::STAT_FULL;
                           end else begin
                              nrm_we                  = 1'b1;
                              nrm_live_in[nrm_wr_idx] = 1'b1;
                              nrm_wr_in               = tlpmq_pkg::nrm_next(nrm_wr_ff);
                           end
                        end
                     end
                     tlpmq_pkg::OP_POP: begin
                        ring_sel_in = 1'b1;
                        state_in    = tlpmq_pkg::ST_POP_SCAN;
                     end
                     tlpmq_pkg::OP_FLUSH_ALL: begin
                        pri_rd_in = pri_wr_ff;
                        nrm_rd_in = nrm_wr_ff;
                     end
                     tlpmq_pkg::OP_FLUSH_SINK: begin
                        ring_sel_in = 1'b1;
                        cur_in      = tlpmq_pkg::CUR_W'(pri_rd_ff);
                        left_in     = tlpmq_pkg::LEFT_W'(pri_cnt);
                        state_in    = tlpmq_pkg::ST_FLUSH_READ;
                     end
                     tlpmq_pkg::OP_STATUS: begin
                        if ((nrm_cnt == '0) && (pri_cnt == '0)) begin
                           status_in = tlpmq_pkg::STAT_EMPTY;
                        end else if ((nrm_cnt >= tlpmq_pkg::NRM_CNT_W'(tlpmq_pkg::NRM_DEPTH)) ||
                                     (pri_cnt >= tlpmq_pkg::PRI_CNT_W'(tlpmq_pkg::PRI_DEPTH))) begin
                           status_in = tlpmq_pkg::STAT_FULL;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         // Drop one head entry per cycle; the first live one is delivered.
         tlpmq_pkg::ST_POP_SCAN: begin
            if (ring_sel_ff) begin
               if (pri_cnt != '0) begin
                  pri_rd_in = tlpmq_pkg::pri_next(pri_rd_ff);
                  if (pri_live_ff[pri_scan_idx]) begin
                     pri_live_in[pri_scan_idx] = 1'b0;
                     hit_in      = 1'b1;
                     hit_prio_in = 1'b1;
                     state_in    = tlpmq_pkg::ST_DONE;
                  end
               end else begin
                  ring_sel_in = 1'b0;
               end
            end else begin
               if (nrm_cnt != '0) begin
                  nrm_rd_in = tlpmq_pkg::nrm_next(nrm_rd_ff);
                  if (nrm_live_ff[nrm_scan_idx]) begin
                     nrm_live_in[nrm_scan_idx] = 1'b0;
                     hit_in   = 1'b1;
                     state_in = tlpmq_pkg::ST_DONE;
                  end
               end else begin
                  status_in = tlpmq_pkg::STAT_EMPTY;
                  state_in  = tlpmq_pkg::ST_DONE;
               end
            end
         end

         // Issue the memory read for the cursor entry, or move to the next ring or finish.
         tlpmq_pkg::ST_FLUSH_READ: begin
            if (left_ff == '0) begin
               if (ring_sel_ff) begin
                  ring_sel_in = 1'b0;
                  cur_in      = tlpmq_pkg::CUR_W'(nrm_rd_ff);
                  left_in     = tlpmq_pkg::LEFT_W'(nrm_cnt);
               end else begin
                  state_in = tlpmq_pkg::ST_DONE;
               end
            end else begin
               state_in = tlpmq_pkg::ST_FLUSH_CHECK;
            end
         end

         // Kill a matching live entry; the read pointer follows only at the head.
         tlpmq_pkg::ST_FLUSH_CHECK: begin
            if (ring_sel_ff) begin
               if (pri_live_ff[pri_scan_idx] && sink_hit) begin
                  pri_live_in[pri_scan_idx] = 1'b0;
                  if (cur_pri == pri_rd_ff) begin
                     pri_rd_in = tlpmq_pkg::pri_next(pri_rd_ff);
                  end
               end
               cur_in = tlpmq_pkg::CUR_W'(tlpmq_pkg::pri_next(cur_pri));
            end else begin
               if (nrm_live_ff[nrm_scan_idx] && sink_hit) begin
                  nrm_live_in[nrm_scan_idx] = 1'b0;
                  if (cur_nrm == nrm_rd_ff) begin
                     nrm_rd_in = tlpmq_pkg::nrm_next(nrm_rd_ff);
                  end
               end
               cur_in = tlpmq_pkg::CUR_W'(tlpmq_pkg::nrm_next(cur_nrm));
            end
            left_in  = left_ff - tlpmq_pkg::LEFT_W'(1);
            state_in = tlpmq_pkg::ST_FLUSH_READ;
         end

         // Hand the word to the result register once it is free.
         tlpmq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = tlpmq_pkg::ST_IDLE;
            end
         end

         default: state_in = tlpmq_pkg::ST_IDLE;
      endcase
   end

   // Result register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      if (!hit_ff) begin
         rsp_entry_in = '0;
      end else if (hit_prio_ff) begin
         rsp_entry_in = pri_rdata_ff;
      end else begin
         rsp_entry_in = nrm_rdata_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlpmq_pkg::ST_IDLE;
         nrm_rd_ff    <= '0;
         nrm_wr_ff    <= '0;
         pri_rd_ff    <= '0;
         pri_wr_ff    <= '0;
         nrm_live_ff  <= '0;
         pri_live_ff  <= '0;
         aborted_ff   <= 1'b0;
         hpv_ff       <= tlpmq_pkg::HIGH_PRIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nrm_rd_ff    <= nrm_rd_in;
         nrm_wr_ff    <= nrm_wr_in;
         pri_rd_ff    <= pri_rd_in;
         pri_wr_ff    <= pri_wr_in;
         nrm_live_ff  <= nrm_live_in;
         pri_live_ff  <= pri_live_in;
         aborted_ff   <= aborted_in;
         hpv_ff       <= hpv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the result payload.
   always_ff @(posedge clock) begin
      ring_sel_ff <= ring_sel_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      sink_ff     <= sink_in;
      status_ff   <= status_in;
      hit_ff      <= hit_in;
      hit_prio_ff <= hit_prio_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_hit_ff    <= hit_ff;
         rsp_prio_ff   <= hit_ff && hit_prio_ff;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_ncnt_ff   <= nrm_cnt;
         rsp_pcnt_ff   <= pri_cnt;
      end
   end

   // Message memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (nrm_we) begin
         nrm_mem[nrm_wr_idx] <= wentry;
      end
      if (mem_re) begin
         nrm_rdata_ff <= nrm_mem[nrm_scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pri_we) begin
         pri_mem[pri_wr_idx] <= wentry;
      end
      if (mem_re) begin
         pri_rdata_ff <= pri_mem[pri_scan_idx];
      end
   end

   // Outputs.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_out_valid         = rsp_hit_ff;
   assign rsp_out_sink_id       = rsp_entry_ff.sink;
   assign rsp_out_code          = rsp_entry_ff.code;
   assign rsp_out_param         = rsp_entry_ff.param;
   assign rsp_out_from_priority = rsp_prio_ff;
   assign rsp_normal_count      = rsp_ncnt_ff;
   assign rsp_priority_count    = rsp_pcnt_ff;

   // Neither ring ever holds more entries than it has places.
   a_ring_bounds : assert property (@(posedge clock) disable iff (reset)
      (nrm_cnt <= tlpmq_pkg::NRM_CNT_W'(tlpmq_pkg::NRM_DEPTH)) &&
      (pri_cnt <= tlpmq_pkg::PRI_CNT_W'(tlpmq_pkg::PRI_DEPTH)))
      else $error("ring occupancy exceeds its depth");

   // A pop only falls through to the normal ring once the priority ring is empty.
   a_pop_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlpmq_pkg::ST_POP_SCAN) && !ring_sel_ff |-> (pri_cnt == '0))
      else $error("normal ring served while priority ring holds entries");

   // A delivered message always carries an ok status.
   a_deliver_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> (rsp_status == tlpmq_pkg::STAT_OK))
      else $error("message delivered with a failing status");

   // The priority mark only accompanies a delivered message.
   a_prio_mark : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_from_priority |-> rsp_out_valid)
      else $error("priority mark set without a message");

   // An aborted word leaves the read and write pointers untouched.
   a_refused_stable : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlpmq_pkg::ST_IDLE) && req_valid && aborted_ff |=>
      ($stable(nrm_wr_ff) && $stable(pri_wr_ff) && $stable(nrm_rd_ff) && $stable(pri_rd_ff)))
      else $error("aborted word changed a ring pointer");

endmodule

`default_nettype wire

// ----- sim/tb_two_level_priority_message_queue_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the two-level priority message queue core
//
// Drives request words through a directed table and then through phases of
// random traffic under several register settings. Each accepted request is
// run through a behavioural copy of both rings, and each response word is
// checked field by field against the oldest predicted reply. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------

module tb_two_level_priority_message_queue_core;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RING_NRM     = 0;
   localparam int RING_PRI     = 1;

   // Operation codes that the core ignores.
   localparam logic [tlpmq_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [tlpmq_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [tlpmq_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      tlpmq_pkg::status_type           status;
      logic                            out_valid;
      logic [tlpmq_pkg::SINK_W-1:0]    sink;
      logic [tlpmq_pkg::WORD_W-1:0]    code;
      logic [tlpmq_pkg::WORD_W-1:0]    param;
      logic                            from_prio;
      logic [tlpmq_pkg::NRM_CNT_W-1:0] ncount;
      logic [tlpmq_pkg::PRI_CNT_W-1:0] pcount;
   } queue_reply_type;

   typedef struct packed {
      logic [tlpmq_pkg::OP_W-1:0]   op;
      logic [tlpmq_pkg::SINK_W-1:0] sink;
      logic [tlpmq_pkg::WORD_W-1:0] code;
      logic [tlpmq_pkg::WORD_W-1:0] param;
      logic                         typed;
      queue_reply_type              reply;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [tlpmq_pkg::OP_W-1:0]      req_op;
   logic [tlpmq_pkg::SINK_W-1:0]    req_sink_id;
   logic [tlpmq_pkg::WORD_W-1:0]    req_msg_code;
   logic [tlpmq_pkg::WORD_W-1:0]    req_msg_param;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [tlpmq_pkg::STATUS_W-1:0]  rsp_status;
   logic                            rsp_out_valid;
   logic [tlpmq_pkg::SINK_W-1:0]    rsp_out_sink_id;
   logic [tlpmq_pkg::WORD_W-1:0]    rsp_out_code;
   logic [tlpmq_pkg::WORD_W-1:0]    rsp_out_param;
   logic                            rsp_out_from_priority;
   logic [tlpmq_pkg::NRM_CNT_W-1:0] rsp_normal_count;
   logic [tlpmq_pkg::PRI_CNT_W-1:0] rsp_priority_count;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [tlpmq_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tlpmq_pkg::WORD_W-1:0]    csr_wdata;

   two_level_priority_message_queue_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_sink_id           (req_sink_id),
      .req_msg_code          (req_msg_code),
      .req_msg_param         (req_msg_param),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_out_valid         (rsp_out_valid),
      .rsp_out_sink_id       (rsp_out_sink_id),
      .rsp_out_code          (rsp_out_code),
      .rsp_out_param         (rsp_out_param),
      .rsp_out_from_priority (rsp_out_from_priority),
      .rsp_normal_count      (rsp_normal_count),
      .rsp_priority_count    (rsp_priority_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // Shadow copy of both rings; index 0 is the normal ring, 1 the priority ring.
   logic [tlpmq_pkg::SINK_W-1:0] ring_sink  [2][tlpmq_pkg::NRM_DEPTH];
   logic [tlpmq_pkg::WORD_W-1:0] ring_code  [2][tlpmq_pkg::NRM_DEPTH];
   logic [tlpmq_pkg::WORD_W-1:0] ring_param [2][tlpmq_pkg::NRM_DEPTH];
   bit                           ring_live  [2][tlpmq_pkg::NRM_DEPTH];
   int                           rd_ptr [2];
   int                           wr_ptr [2];
   bit                           cfg_aborted;
   logic [tlpmq_pkg::WORD_W-1:0] cfg_high_prio;

   queue_reply_type pending_replies [$];
   stim_row_type    directed_rows [$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              idle_on = 1'b1;

   always #10 clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_two_level_priority_message_queue_core: FAIL");
         $finish;
      end
   end

   function automatic int depth_of(input int r);
      return (r == RING_PRI) ? tlpmq_pkg::PRI_DEPTH : tlpmq_pkg::NRM_DEPTH;
   endfunction

   function automatic int ring_fill(input int r);
      int span;
      span = 2 * depth_of(r);
      return (wr_ptr[r] - rd_ptr[r] + span) % span;
   endfunction

   function automatic int step_ptr(input int r, input int p);
      return (p + 1 >= 2 * depth_of(r)) ? 0 : p + 1;
   endfunction

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 30);
   endfunction

   function automatic queue_reply_type make_reply(input tlpmq_pkg::status_type st,
                                                  input logic ov,
                                                  input logic [tlpmq_pkg::SINK_W-1:0] s,
                                                  input logic [tlpmq_pkg::WORD_W-1:0] c,
                                                  input logic [tlpmq_pkg::WORD_W-1:0] p,
                                                  input logic fp, input int nc,
                                                  input int pc);
      queue_reply_type rep;
      rep.status    = st;
      rep.out_valid = ov;
      rep.sink      = s;
      rep.code      = c;
      rep.param     = p;
      rep.from_prio = fp;
      rep.ncount    = tlpmq_pkg::NRM_CNT_W'(nc);
      rep.pcount    = tlpmq_pkg::PRI_CNT_W'(pc);
      return rep;
   endfunction

   // Drop dead head entries and hand out the first live one, if any.
   task automatic ring_take(input int r, output bit hit,
                            output logic [tlpmq_pkg::SINK_W-1:0] s,
                            output logic [tlpmq_pkg::WORD_W-1:0] c,
                            output logic [tlpmq_pkg::WORD_W-1:0] p);
      int idx;
      hit = 1'b0;
      s   = '0;
      c   = '0;
      p   = '0;
      while (!hit && ring_fill(r) > 0) begin
         idx = rd_ptr[r] % depth_of(r);
         rd_ptr[r] = step_ptr(r, rd_ptr[r]);
         if (ring_live[r][idx]) begin
            ring_live[r][idx] = 1'b0;
            hit = 1'b1;
            s   = ring_sink[r][idx];
            c   = ring_code[r][idx];
            p   = ring_param[r][idx];
         end
      end
   endtask

   // Kill every live entry of one sink; the read pointer only follows a run
   // of matches that starts at the head.
   task automatic kill_sink(input int r, input logic [tlpmq_pkg::SINK_W-1:0] s);
      int n;
      int i;
      int idx;
      n = ring_fill(r);
      i = rd_ptr[r];
      for (int k = 0; k < n; k++) begin
         idx = i % depth_of(r);
         if (ring_live[r][idx] && ring_sink[r][idx] == s) begin
            ring_live[r][idx] = 1'b0;
            if (i == rd_ptr[r]) begin
               rd_ptr[r] = step_ptr(r, rd_ptr[r]);
            end
         end
         i = step_ptr(r, i);
      end
   endtask

   // Apply one request word to the shadow rings and work out its reply.
   task automatic predict_reply(input logic [tlpmq_pkg::OP_W-1:0] op,
                                input logic [tlpmq_pkg::SINK_W-1:0] sink,
                                input logic [tlpmq_pkg::WORD_W-1:0] code,
                                input logic [tlpmq_pkg::WORD_W-1:0] param,
                                output queue_reply_type rep);
      int r;
      int idx;
      int nc;
      int pc;
      bit hit;
      logic [tlpmq_pkg::SINK_W-1:0] s;
      logic [tlpmq_pkg::WORD_W-1:0] c;
      logic [tlpmq_pkg::WORD_W-1:0] p;
      rep = '0;
      rep.status = tlpmq_pkg::STAT_OK;
      if (cfg_aborted) begin
         rep.status = tlpmq_pkg::STAT_ABORTED;
      end else begin
         case (op)
            tlpmq_pkg::OP_PUSH: begin
               r = (param == cfg_high_prio) ? RING_PRI : RING_NRM;
               if (ring_fill(r) >= depth_of(r)) begin
                  rep.status = tlpmq_pkg::STAT_FULL;
               end else begin
                  idx = wr_ptr[r] % depth_of(r);
                  ring_sink[r][idx]  = sink;
                  ring_code[r][idx]  = code;
                  ring_param[r][idx] = param;
                  ring_live[r][idx]  = 1'b1;
                  wr_ptr[r] = step_ptr(r, wr_ptr[r]);
               end
            end
            tlpmq_pkg::OP_POP: begin
               ring_take(RING_PRI, hit, s, c, p);
               rep.from_prio = hit;
               if (!hit) begin
                  ring_take(RING_NRM, hit, s, c, p);
               end
               if (hit) begin
                  rep.out_valid = 1'b1;
                  rep.sink      = s;
                  rep.code      = c;
                  rep.param     = p;
               end else begin
                  rep.status = tlpmq_pkg::STAT_EMPTY;
               end
            end
            tlpmq_pkg::OP_FLUSH_ALL: begin
               rd_ptr[RING_PRI] = wr_ptr[RING_PRI];
               rd_ptr[RING_NRM] = wr_ptr[RING_NRM];
            end
            tlpmq_pkg::OP_FLUSH_SINK: begin
               kill_sink(RING_PRI, sink);
               kill_sink(RING_NRM, sink);
            end
            tlpmq_pkg::OP_STATUS: begin
               nc = ring_fill(RING_NRM);
               pc = ring_fill(RING_PRI);
               if (nc == 0 && pc == 0) begin
                  rep.status = tlpmq_pkg::STAT_EMPTY;
               end else if (nc >= tlpmq_pkg::NRM_DEPTH || pc >= tlpmq_pkg::PRI_DEPTH) begin
                  rep.status = tlpmq_pkg::STAT_FULL;
               end
            end
            default: begin
            end
         endcase
      end
      rep.ncount = tlpmq_pkg::NRM_CNT_W'(ring_fill(RING_NRM));
      rep.pcount = tlpmq_pkg::PRI_CNT_W'(ring_fill(RING_PRI));
   endtask

   task automatic compare_field(input string fname,
                                input logic [tlpmq_pkg::WORD_W-1:0] want,
                                input logic [tlpmq_pkg::WORD_W-1:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch in %s: expected %h, got %h", fname, want, seen);
         end
      end
   endtask

   // Response monitor: every accepted word is matched against the oldest
   // predicted reply.
   always @(posedge clock) begin : reply_check
      queue_reply_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("response word with no reply outstanding");
            end
         end else begin
            want = pending_replies.pop_front();
            compare_field("status", tlpmq_pkg::WORD_W'(want.status),
                          tlpmq_pkg::WORD_W'(rsp_status));
            compare_field("out_valid", tlpmq_pkg::WORD_W'(want.out_valid),
                          tlpmq_pkg::WORD_W'(rsp_out_valid));
            compare_field("out_sink_id", tlpmq_pkg::WORD_W'(want.sink),
                          tlpmq_pkg::WORD_W'(rsp_out_sink_id));
            compare_field("out_code", want.code, rsp_out_code);
            compare_field("out_param", want.param, rsp_out_param);
            compare_field("out_from_priority", tlpmq_pkg::WORD_W'(want.from_prio),
                          tlpmq_pkg::WORD_W'(rsp_out_from_priority));
            compare_field("normal_count", tlpmq_pkg::WORD_W'(want.ncount),
                          tlpmq_pkg::WORD_W'(rsp_normal_count));
            compare_field("priority_count", tlpmq_pkg::WORD_W'(want.pcount),
                          tlpmq_pkg::WORD_W'(rsp_priority_count));
         end
      end
   end

   // Response back-pressure: random stalls between runs of readiness.
   initial begin : rsp_stall
      int gap;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Send one request word, then record the reply it should produce.
   task automatic issue_word(input logic [tlpmq_pkg::OP_W-1:0] op,
                             input logic [tlpmq_pkg::SINK_W-1:0] sink,
                             input logic [tlpmq_pkg::WORD_W-1:0] code,
                             input logic [tlpmq_pkg::WORD_W-1:0] param,
                             input logic typed, input queue_reply_type typed_rep);
      int gap;
      queue_reply_type rep;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_sink_id   <= sink;
      req_msg_code  <= code;
      req_msg_param <= param;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_reply(op, sink, code, param, rep);
      pending_replies.push_back(typed ? typed_rep : rep);
   endtask

   task automatic add_row(input logic [tlpmq_pkg::OP_W-1:0] op,
                          input logic [tlpmq_pkg::SINK_W-1:0] sink,
                          input logic [tlpmq_pkg::WORD_W-1:0] code,
                          input logic [tlpmq_pkg::WORD_W-1:0] param,
                          input logic typed, input queue_reply_type rep);
      stim_row_type row;
      row.op    = op;
      row.sink  = sink;
      row.code  = code;
      row.param = param;
      row.typed = typed;
      row.reply = rep;
      directed_rows.push_back(row);
   endtask

   // Stop sending and let every outstanding reply come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back while the core is idle.
   task automatic apply_config(input logic abort_on,
                               input logic [tlpmq_pkg::WORD_W-1:0] high_prio);
      csr_valid <= 1'b1;
      csr_index <= tlpmq_pkg::CSR_ABORTED;
      csr_wdata <= {{(tlpmq_pkg::WORD_W-1){1'b0}}, abort_on};
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_aborted = abort_on;
      csr_index <= tlpmq_pkg::CSR_HIGH_PRIO;
      csr_wdata <= high_prio;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_high_prio = high_prio;
      csr_valid <= 1'b0;
   endtask

   // Random traffic in bursts: fill runs, drain runs and mixed runs, with
   // sinks drawn mostly from a small pool so that flushes find matches.
   task automatic run_traffic(input int count);
      logic [tlpmq_pkg::SINK_W-1:0] pool [4];
      logic [tlpmq_pkg::OP_W-1:0]   op;
      logic [tlpmq_pkg::SINK_W-1:0] sink;
      logic [tlpmq_pkg::WORD_W-1:0] param;
      int mode_left;
      int push_pct;
      int pop_end;
      int prio_pct;
      int r;
      mode_left = 0;
      push_pct  = 40;
      pop_end   = 80;
      prio_pct  = 40;
      for (int k = 0; k < 4; k++) begin
         pool[k] = tlpmq_pkg::SINK_W'($urandom_range(0, 255));
      end
      for (int n = 0; n < count; n++) begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(16, 48);
            case ($urandom_range(0, 2))
               0: begin
                  push_pct = 72;
                  pop_end  = 80;
                  prio_pct = 25;
               end
               1: begin
                  push_pct = 20;
                  pop_end  = 80;
                  prio_pct = 45;
               end
               default: begin
                  push_pct = 42;
                  pop_end  = 80;
                  prio_pct = 45;
               end
            endcase
         end
         mode_left--;
         r = $urandom_range(0, 99);
         if (r < push_pct) begin
            op = tlpmq_pkg::OP_PUSH;
         end else if (r < pop_end) begin
            op = tlpmq_pkg::OP_POP;
         end else if (r < pop_end + 10) begin
            op = tlpmq_pkg::OP_FLUSH_SINK;
         end else if (r < pop_end + 16) begin
            op = tlpmq_pkg::OP_STATUS;
         end else if (r < pop_end + 18) begin
            op = tlpmq_pkg::OP_FLUSH_ALL;
         end else begin
            op = tlpmq_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end
         sink = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 3)]
                                              : tlpmq_pkg::SINK_W'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < prio_pct) begin
            param = cfg_high_prio;
         end else if (r < prio_pct + 10) begin
            param = cfg_high_prio ^ (32'd1 << $urandom_range(0, 31));
         end else begin
            param = $urandom;
         end
         issue_word(op, sink, $urandom, param, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      stim_row_type row;

      // Known values on every input from the first instant.
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_op        <= tlpmq_pkg::OP_PUSH;
      req_sink_id   <= '0;
      req_msg_code  <= '0;
      req_msg_param <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= tlpmq_pkg::CSR_ABORTED;
      csr_wdata     <= '0;

      // Shadow state as the core leaves reset.
      for (int r = 0; r < 2; r++) begin
         rd_ptr[r] = 0;
         wr_ptr[r] = 0;
         for (int i = 0; i < tlpmq_pkg::NRM_DEPTH; i++) begin
            ring_live[r][i] = 1'b0;
         end
      end
      cfg_aborted   = 1'b0;
      cfg_high_prio = tlpmq_pkg::HIGH_PRIO_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty rings, extreme words, both rings, the ignored
      // codes, a full priority ring, flushes by sink with and without a
      // matching head run, a pop that only drops dead entries, flush-all.
      add_row(tlpmq_pkg::OP_STATUS, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_EMPTY, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));
      add_row(tlpmq_pkg::OP_POP, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_EMPTY, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));
      add_row(tlpmq_pkg::OP_PUSH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 1, 0));
      add_row(tlpmq_pkg::OP_PUSH, 8'h00, 32'h0, tlpmq_pkg::HIGH_PRIO_RESET, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 1, 1));
      add_row(tlpmq_pkg::OP_STATUS, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 1, 1));
      add_row(tlpmq_pkg::OP_POP, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b1, 8'h00, 32'h0,
                         tlpmq_pkg::HIGH_PRIO_RESET, 1'b1, 1, 0));
      add_row(tlpmq_pkg::OP_POP, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         1'b0, 0, 0));
      add_row(OP_SPARE_FIRST, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));
      add_row(OP_SPARE_MID, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));
      add_row(OP_SPARE_LAST, 8'h00, 32'h0, tlpmq_pkg::HIGH_PRIO_RESET, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));
      add_row(tlpmq_pkg::OP_PUSH, 8'h03, 32'h100, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h03, 32'h101, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h04, 32'h102, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h03, 32'h103, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h04, 32'h104, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h04, 32'h105, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h03, 32'h106, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h04, 32'h107, tlpmq_pkg::HIGH_PRIO_RESET, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h80, 32'hA5A5_A5A5, tlpmq_pkg::HIGH_PRIO_RESET, 1'b1,
              make_reply(tlpmq_pkg::STAT_FULL, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0,
                         tlpmq_pkg::PRI_DEPTH));
      add_row(tlpmq_pkg::OP_STATUS, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_FULL, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0,
                         tlpmq_pkg::PRI_DEPTH));
      add_row(tlpmq_pkg::OP_FLUSH_SINK, 8'h03, 32'h0, 32'h0, 1'b0, '0);
      add_row(tlpmq_pkg::OP_POP, 8'h00, 32'h0, 32'h0, 1'b0, '0);
      add_row(tlpmq_pkg::OP_FLUSH_SINK, 8'h04, 32'h0, 32'h0, 1'b0, '0);
      add_row(tlpmq_pkg::OP_POP, 8'h00, 32'h0, 32'h0, 1'b0, '0);
      add_row(tlpmq_pkg::OP_PUSH, 8'h55, 32'h1234_5678, 32'h0000_005A, 1'b0, '0);
      add_row(tlpmq_pkg::OP_FLUSH_ALL, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_OK, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));
      add_row(tlpmq_pkg::OP_POP, 8'h00, 32'h0, 32'h0, 1'b1,
              make_reply(tlpmq_pkg::STAT_EMPTY, 1'b0, 8'h00, 32'h0, 32'h0, 1'b0, 0, 0));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue_word(row.op, row.sink, row.code, row.param, row.typed, row.reply);
      end
      drain_replies();

      // Random phases under different register settings, the extremes among
      // them; the last phase runs with no idling on either side.
      apply_config(1'b0, 32'h0000_0000);
      run_traffic(150);
      drain_replies();
      apply_config(1'b0, 32'hFFFF_FFFF);
      run_traffic(150);
      drain_replies();
      apply_config(1'b1, 32'hFFFF_FFFF);
      run_traffic(40);
      drain_replies();
      apply_config(1'b0, $urandom);
      run_traffic(180);
      drain_replies();
      idle_on = 1'b0;
      apply_config(1'b0, tlpmq_pkg::HIGH_PRIO_RESET);
      run_traffic(180);
      drain_replies();

      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("tb_two_level_priority_message_queue_core: PASS");
      end else begin
         $display("tb_two_level_priority_message_queue_core: FAIL");
      end
      $finish;
   end

endmodule
